### rtl/assert_macros.svh
// Assertion macros shared by the profiler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// check an implication on the following clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### rtl/rtap_pkg.sv
// Package for the rotate-then-advance trapezoid profiler: types, constants
`timescale 1ns / 1ps
package rtap_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam logic [30:0] DEF_TURN_RESET = 31'd65536;
   localparam logic [30:0] DEF_SPEED_RESET = 31'd19661;
   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

   localparam logic [1:0] OP_PLAN = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;
   localparam logic [1:0] OP_RESTART = 2'd3;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ROT = 2'd1;
   localparam logic [1:0] PH_ADV = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam logic CSR_TURN = 1'b0;
   localparam logic CSR_SPEED = 1'b1;

   typedef struct packed {
      logic [1:0] opcode;
      logic signed [31:0] turn_angle;
      logic signed [31:0] distance;
      logic signed [31:0] turn_peak;
      logic signed [31:0] speed_peak;
      logic [30:0] time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] linear_speed;
      logic signed [31:0] turn_rate;
      logic [1:0] phase;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

### rtl/rtap_div.sv
// Bit-serial restoring divider: one quotient bit per cycle
`timescale 1ns / 1ps
module rtap_div import rtap_pkg::*; #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 33
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [NUM_W-1:0] numer,
   input logic [DEN_W-1:0] denom,
   output div_ctl_type ctl,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0] shifted;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in = numer;
         r_in = '0;
         d_in = denom;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, d_ff}) begin
            r_in = shifted - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot = q_ff;
   assign ctl = '{start: start, busy: busy_ff, done: done_ff};

endmodule

### rtl/rtap_mul.sv
// Shift-and-add multiplier: one multiplier bit per cycle
`timescale 1ns / 1ps
module rtap_mul import rtap_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [30:0] mcand,
   input logic [31:0] mplier,
   output div_ctl_type ctl,
   output logic [62:0] prod
);

   logic [62:0] acc_ff, acc_in;
   logic [62:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         a_in = {32'd0, mcand};
         b_in = mplier;
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in = {a_ff[61:0], 1'b0};
         b_in = {1'b0, b_ff[31:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign prod = acc_ff;
   assign ctl = '{start: start, busy: busy_ff, done: done_ff};

endmodule

### rtl/rotate_then_advance_trapezoid_profiler.sv
// Rotate-then-advance trapezoid profiler: one transaction in, one result out.
// A plan runs two serial divisions of the durations. A tick on a ramp runs a serial
// divide for the ramp end point, a serial multiply, then a serial divide. A tick in
// the flat part runs only the serial divide for the ramp end point. A tick that ends
// a phase, a tick at zero elapsed time, a tick while idle or done, cancel and
// restart use neither the divider nor the multiplier. One transaction is in work at
// a time; the result register frees the input side as soon as the result is loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rotate_then_advance_trapezoid_profiler import rtap_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data,
   input logic csr_write,
   input logic csr_index,
   input logic [30:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_PL_TURN, S_PL_TURN_W, S_PL_MOVE, S_PL_MOVE_W, S_PL_END,
      S_TK, S_TK_T1, S_TK_T1_W, S_TK_MUL_W, S_TK_DIV_W, S_OUT
   } state_type;

   state_type state_ff;
   req_type req_ff;
   logic [30:0] dflt_turn_ff, dflt_speed_ff;
   logic [1:0] phase_ff;
   logic [30:0] elapsed_ff, tdur_ff, tpeak_ff, mdur_ff, mpeak_ff;
   logic tneg_ff, tnz_ff, mneg_ff, mnz_ff;
   logic signed [31:0] speed_ff, rate_ff;
   logic [30:0] t1_ff;
   logic up_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic div_start, mul_start;
   logic [63:0] div_num, div_q;
   logic [32:0] div_den;
   logic [30:0] mul_a;
   logic [31:0] mul_b;
   logic [62:0] mul_p;
   div_ctl_type div_ctl, mul_ctl;

   rtap_div #(.NUM_W(64), .DEN_W(33)) u_div (
      .clock, .reset, .start(div_start), .numer(div_num), .denom(div_den),
      .ctl(div_ctl), .quot(div_q)
   );

   rtap_mul u_mul (
      .clock, .reset, .start(mul_start), .mcand(mul_a), .mplier(mul_b),
      .ctl(mul_ctl), .prod(mul_p)
   );

   logic [31:0] tmag, mmag;
   logic [30:0] tpk_sel, mpk_sel;
   logic in_rot;
   logic [30:0] cur_dur, cur_peak, tdn, seg_up, seg_dn;
   logic [31:0] t_sum;
   logic [30:0] t_now;

   assign tmag = req_ff.turn_angle[31] ? 32'(-req_ff.turn_angle) : req_ff.turn_angle;
   assign mmag = req_ff.distance[31] ? 32'(-req_ff.distance) : req_ff.distance;
   assign tpk_sel = (!req_ff.turn_peak[31] && req_ff.turn_peak != 0) ?
                    req_ff.turn_peak[30:0] : dflt_turn_ff;
   assign mpk_sel = (!req_ff.speed_peak[31] && req_ff.speed_peak != 0) ?
                    req_ff.speed_peak[30:0] : dflt_speed_ff;
   assign in_rot = (phase_ff == PH_ROT);
   assign cur_dur = in_rot ? tdur_ff : mdur_ff;
   assign cur_peak = in_rot ? tpeak_ff : mpeak_ff;
   assign t_sum = {1'b0, elapsed_ff} + {1'b0, req_ff.time_step};
   assign t_now = t_sum[31] ? MAX31 : t_sum[30:0];
   assign seg_up = t1_ff;
   assign seg_dn = cur_dur - {t1_ff[29:0], 1'b0};
   assign tdn = cur_dur - elapsed_ff;

   always_comb begin
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      mul_start = 1'b0;
      mul_a = cur_peak;
      mul_b = (elapsed_ff < div_q[30:0]) ? {1'b0, elapsed_ff} : {1'b0, tdn};
      unique case (state_ff)
         S_PL_TURN: begin
            div_start = 1'b1;
            div_num = 64'((({2'b0, tmag} + {1'b0, tmag, 1'b0}) << FRAC_BITS));
            div_den = {1'b0, tpk_sel, 1'b0};
         end
         S_PL_MOVE: begin
            div_start = 1'b1;
            div_num = 64'((({2'b0, mmag} + {1'b0, mmag, 1'b0}) << FRAC_BITS));
            div_den = {1'b0, mpk_sel, 1'b0};
         end
         S_TK_T1: begin
            div_start = 1'b1;
            div_num = {33'd0, cur_dur};
            div_den = 33'd3;
         end
         S_TK_MUL_W: begin
            div_start = mul_ctl.done;
            div_num = {1'b0, mul_p};
            div_den = up_ff ? {2'b0, seg_up} : {2'b0, seg_dn};
         end
         default: ;
      endcase
      if (state_ff == S_TK_T1_W && div_ctl.done) mul_start = 1'b1;
   end

   assign req_stall = (state_ff != S_IDLE);

   function automatic logic [30:0] sat31(input logic [63:0] q);
      sat31 = (q[63:31] != 0) ? MAX31 : q[30:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dflt_turn_ff <= DEF_TURN_RESET;
         dflt_speed_ff <= DEF_SPEED_RESET;
         phase_ff <= PH_IDLE;
         elapsed_ff <= '0;
         tdur_ff <= '0;
         tpeak_ff <= '0;
         mdur_ff <= '0;
         mpeak_ff <= '0;
         tneg_ff <= 1'b0;
         tnz_ff <= 1'b0;
         mneg_ff <= 1'b0;
         mnz_ff <= 1'b0;
         speed_ff <= '0;
         rate_ff <= '0;
         rsp_valid_ff <= 1'b0;
         t1_ff <= '0;
         up_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_TURN: dflt_turn_ff <= csr_wdata;
               CSR_SPEED: dflt_speed_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  unique case (req_data.opcode)
                     OP_PLAN: state_ff <= S_PL_TURN;
                     OP_TICK: state_ff <= S_TK;
                     OP_CANCEL: begin
                        phase_ff <= PH_DONE;
                        speed_ff <= '0;
                        rate_ff <= '0;
                        state_ff <= S_OUT;
                     end
                     default: begin
                        if (phase_ff == PH_ROT || phase_ff == PH_ADV) elapsed_ff <= '0;
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_PL_TURN: begin
               tneg_ff <= req_ff.turn_angle[31];
               tnz_ff <= (tmag != 0);
               tpeak_ff <= (tmag == 0 || tpk_sel == 0) ? '0 : tpk_sel;
               state_ff <= S_PL_TURN_W;
            end
            S_PL_TURN_W: if (div_ctl.done) begin
               tdur_ff <= (tpeak_ff == 0) ? '0 : sat31(div_q);
               state_ff <= S_PL_MOVE;
            end
            S_PL_MOVE: begin
               mneg_ff <= req_ff.distance[31];
               mnz_ff <= (mmag != 0);
               mpeak_ff <= (mmag == 0 || mpk_sel == 0) ? '0 : mpk_sel;
               state_ff <= S_PL_MOVE_W;
            end
            S_PL_MOVE_W: if (div_ctl.done) begin
               mdur_ff <= (mpeak_ff == 0) ? '0 : sat31(div_q);
               state_ff <= S_PL_END;
            end
            S_PL_END: begin
               elapsed_ff <= '0;
               if (tnz_ff) phase_ff <= PH_ROT;
               else if (mnz_ff) phase_ff <= PH_ADV;
               else begin
                  phase_ff <= PH_DONE;
                  speed_ff <= '0;
                  rate_ff <= '0;
               end
               state_ff <= S_OUT;
            end
            S_TK: begin
               if (phase_ff == PH_ROT || phase_ff == PH_ADV) begin
                  elapsed_ff <= t_now;
                  if (t_now >= cur_dur || cur_peak == 0) begin
                     speed_ff <= '0;
                     rate_ff <= '0;
                     if (in_rot && mnz_ff) begin
                        phase_ff <= PH_ADV;
                        elapsed_ff <= '0;
                     end else if (t_now >= cur_dur) phase_ff <= PH_DONE;
                     state_ff <= S_OUT;
                  end else if (t_now == 0) begin
                     speed_ff <= '0;
                     rate_ff <= '0;
                     state_ff <= S_OUT;
                  end else state_ff <= S_TK_T1;
               end else state_ff <= S_OUT;
            end
            S_TK_T1: state_ff <= S_TK_T1_W;
            S_TK_T1_W: if (div_ctl.done) begin
               t1_ff <= div_q[30:0];
               up_ff <= (elapsed_ff < div_q[30:0]);
               if (elapsed_ff >= div_q[30:0] && elapsed_ff < {div_q[29:0], 1'b0}) begin
                  if (in_rot) begin
                     rate_ff <= tneg_ff ? -$signed({1'b0, cur_peak}) : {1'b0, cur_peak};
                     speed_ff <= '0;
                  end else begin
                     speed_ff <= mneg_ff ? -$signed({1'b0, cur_peak}) : {1'b0, cur_peak};
                     rate_ff <= '0;
                  end
                  state_ff <= S_OUT;
               end else state_ff <= S_TK_MUL_W;
            end
            S_TK_MUL_W: if (mul_ctl.done) state_ff <= S_TK_DIV_W;
            S_TK_DIV_W: if (div_ctl.done) begin
               if (in_rot) begin
                  rate_ff <= tneg_ff ? -$signed({1'b0, div_q[30:0]}) : {1'b0, div_q[30:0]};
                  speed_ff <= '0;
               end else begin
                  speed_ff <= mneg_ff ? -$signed({1'b0, div_q[30:0]}) : {1'b0, div_q[30:0]};
                  rate_ff <= '0;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{linear_speed: speed_ff, turn_rate: rate_ff, phase: phase_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `ASSERT_IMPLY(a_stall_busy, clock, reset, state_ff != S_IDLE, req_stall, "busy without stall")
   `ASSERT_NEXT(a_accept_work, clock, reset, req_valid && !req_stall, state_ff != S_IDLE,
      "accepted transaction not in work")
   `ASSERT_IMPLY(a_idle_zero, clock, reset, rsp_valid && (rsp_data.phase == PH_IDLE ||
      rsp_data.phase == PH_DONE), rsp_data.linear_speed == 0 && rsp_data.turn_rate == 0,
      "nonzero output while idle or done")

endmodule

### verif/tb_rotate_then_advance_trapezoid_profiler.sv
// Testbench for the rotate-then-advance trapezoid profiler: directed and random plans and ticks
`timescale 1ns / 1ps
module tb_rotate_then_advance_trapezoid_profiler;
   import rtap_pkg::*;

   localparam int FRAC = 16;
   localparam int LIMIT = 20000;

   class profile_scoreboard;
      logic [30:0] dflt_rate, dflt_speed;
      logic [1:0] ph;
      logic [31:0] elapsed, turn_dur, turn_pk, move_dur, move_pk;
      logic turn_neg, turn_nz, move_neg, move_nz;
      logic signed [31:0] speed_out, rate_out;
      rsp_type pending[$];
      int errors;

      function new();
         dflt_rate = DEF_TURN_RESET;
         dflt_speed = DEF_SPEED_RESET;
         ph = PH_IDLE;
         elapsed = 0; turn_dur = 0; turn_pk = 0; move_dur = 0; move_pk = 0;
         turn_neg = 0; turn_nz = 0; move_neg = 0; move_nz = 0;
         speed_out = 0; rate_out = 0; errors = 0;
      endfunction

      function void set_default(logic idx, logic [30:0] v);
         if (idx == CSR_TURN) dflt_rate = v;
         else dflt_speed = v;
      endfunction

      function void plan_leg(logic signed [31:0] mv, logic signed [31:0] req,
                             logic [30:0] dflt, output logic [31:0] dur,
                             output logic [31:0] pk, output logic neg,
                             output logic nz);
         logic [63:0] mag, p, q;
         mag = mv < 0 ? -64'(mv) : 64'(mv);
         p = req > 0 ? 64'(req) : 64'(dflt);
         neg = mv < 0;
         nz = mag != 0;
         if (mag == 0 || p == 0) begin
            dur = 0; pk = 0;
         end else begin
            q = ((3 * mag) << FRAC) / (2 * p);
            dur = q > 64'(MAX31) ? 32'(MAX31) : q[31:0];
            pk = p[31:0];
         end
      endfunction

      function logic [63:0] trapezoid(logic [63:0] t, logic [63:0] tf, logic [63:0] pk);
         logic [63:0] t1, t2;
         if (tf == 0 || pk == 0 || t == 0 || t >= tf) return 0;
         t1 = tf / 3;
         t2 = 2 * t1;
         if (t < t1) return pk * t / t1;
         if (t < t2) return pk;
         return pk * (tf - t) / (tf - t2);
      endfunction

      function void note_request(req_type r);
         logic [63:0] t, m;
         rsp_type e;
         case (r.opcode)
            OP_PLAN: begin
               plan_leg(r.turn_angle, r.turn_peak, dflt_rate, turn_dur, turn_pk,
                        turn_neg, turn_nz);
               plan_leg(r.distance, r.speed_peak, dflt_speed, move_dur, move_pk,
                        move_neg, move_nz);
               elapsed = 0;
               if (turn_nz) ph = PH_ROT;
               else if (move_nz) ph = PH_ADV;
               else begin
                  ph = PH_DONE; speed_out = 0; rate_out = 0;
               end
            end
            OP_TICK: begin
               if (ph == PH_ROT || ph == PH_ADV) begin
                  t = 64'(elapsed) + 64'(r.time_step);
                  if (t > 64'(MAX31)) t = 64'(MAX31);
                  elapsed = t[31:0];
                  if (ph == PH_ROT) begin
                     m = trapezoid(t, turn_dur, turn_pk);
                     rate_out = turn_neg ? -m[31:0] : m[31:0];
                     speed_out = 0;
                     if (t >= 64'(turn_dur)) begin
                        rate_out = 0;
                        if (move_nz) begin
                           ph = PH_ADV; elapsed = 0;
                        end else ph = PH_DONE;
                     end
                  end else begin
                     m = trapezoid(t, move_dur, move_pk);
                     speed_out = move_neg ? -m[31:0] : m[31:0];
                     rate_out = 0;
                     if (t >= 64'(move_dur)) begin
                        speed_out = 0; ph = PH_DONE;
                     end
                  end
               end
            end
            OP_CANCEL: begin
               ph = PH_DONE; speed_out = 0; rate_out = 0;
            end
            default: if (ph == PH_ROT || ph == PH_ADV) elapsed = 0;
         endcase
         e.linear_speed = speed_out;
         e.turn_rate = rate_out;
         e.phase = ph;
         pending.push_back(e);
      endfunction

      task check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report_mismatch("result with nothing expected");
            return;
         end
         e = pending.pop_front();
         if (got.linear_speed !== e.linear_speed)
            report_mismatch($sformatf("linear_speed %0d, want %0d",
                                      got.linear_speed, e.linear_speed));
         if (got.turn_rate !== e.turn_rate)
            report_mismatch($sformatf("turn_rate %0d, want %0d",
                                      got.turn_rate, e.turn_rate));
         if (got.phase !== e.phase)
            report_mismatch($sformatf("phase %0d, want %0d", got.phase, e.phase));
      endtask

      task report_mismatch(string s);
         $display("mismatch: %s", s);
         errors++;
      endtask
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_write, csr_index;
   logic [30:0] csr_wdata;
   profile_scoreboard board;
   int idle_cycles;
   bit hold_off;

   rotate_then_advance_trapezoid_profiler DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function int gap_length();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
      return $urandom_range(1, 3);
   endfunction

   function logic [31:0] wide_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 0;
         3: return $urandom;
         default: return 32'($signed($urandom_range(0, 400000)) - 200000);
      endcase
   endfunction

   task automatic send(req_type r);
      int g;
      g = gap_length();
      repeat (g + 1) @(posedge clock);
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      req_valid <= 0;
   endtask

   task automatic plan(logic [31:0] a, logic [31:0] d, logic [31:0] tp, logic [31:0] sp);
      req_type r;
      r = '0;
      r.opcode = OP_PLAN;
      r.turn_angle = a; r.distance = d; r.turn_peak = tp; r.speed_peak = sp;
      r.time_step = 31'($urandom);
      send(r);
   endtask

   task automatic other(logic [1:0] op, logic [30:0] ts);
      req_type r;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, 1'b0};
      r.opcode = op;
      r.time_step = ts;
      send(r);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_default(logic idx, logic [30:0] v);
      csr_write <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_write <= 0;
      board.set_default(idx, v);
      @(posedge clock);
   endtask

   task automatic run_motion();
      int n;
      plan($urandom_range(0, 3) == 0 ? 0 : wide_value() >>> $urandom_range(0, 12),
           $urandom_range(0, 4) == 0 ? 0 : wide_value() >>> $urandom_range(0, 12),
           $urandom_range(0, 2) == 0 ? wide_value() : $urandom_range(1 << 14, 1 << 20),
           $urandom_range(0, 2) == 0 ? wide_value() : $urandom_range(1 << 12, 1 << 18));
      n = $urandom_range(3, 14);
      repeat (n) begin
         case ($urandom_range(0, 19))
            0: other(OP_CANCEL, 31'($urandom));
            1: other(OP_RESTART, 31'($urandom));
            2: other(OP_TICK, 31'($urandom));
            default: other(OP_TICK, 31'($urandom_range(0, 1 << 17)));
         endcase
      end
   endtask

   // receiver side
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      rsp_stall <= hold_off ? 1'b1 : ($urandom_range(0, 3) == 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      board = new();
      reset = 1; req_valid = 0; req_data = '0;
      csr_write = 0; csr_index = 0; csr_wdata = 0; hold_off = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: idle behavior, extremes, zero moves, restart, cancel
      other(OP_TICK, 31'h7FFF_FFFF);
      other(OP_RESTART, 0);
      plan(0, 0, 0, 0);
      other(OP_TICK, 100);
      plan(32'h0001_0000, 32'h0000_8000, 0, 32'h8000_0000);
      other(OP_TICK, 31'h0000_2000);
      other(OP_TICK, 31'h0000_4000);
      other(OP_RESTART, 0);
      other(OP_TICK, 31'h0001_0000);
      other(OP_TICK, 31'h7FFF_FFFF);
      other(OP_TICK, 31'h0000_3000);
      other(OP_TICK, 31'h7FFF_FFFF);
      plan(32'h8000_0000, 32'h7FFF_FFFF, 1, 1);
      other(OP_TICK, 31'h7FFF_FFFF);
      other(OP_TICK, 31'h7FFF_FFFF);
      plan(32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      other(OP_TICK, 1);
      other(OP_CANCEL, 0);
      other(OP_RESTART, 0);
      plan(0, 32'hFFFF_8000, 32'h0002_0000, 0);
      other(OP_TICK, 31'h0000_1000);
      drain();
      write_default(CSR_TURN, 0);
      write_default(CSR_SPEED, 0);
      plan(32'h0001_0000, 32'h0001_0000, 0, 0);
      other(OP_TICK, 1);
      other(OP_TICK, 1);
      drain();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin write_default(CSR_TURN, 31'h7FFF_FFFF); write_default(CSR_SPEED, 1); end
            1: begin write_default(CSR_TURN, 1); write_default(CSR_SPEED, 31'h7FFF_FFFF); end
            2: begin
               write_default(CSR_TURN, 31'($urandom));
               write_default(CSR_SPEED, 31'($urandom));
            end
            default: begin
               write_default(CSR_TURN, DEF_TURN_RESET);
               write_default(CSR_SPEED, DEF_SPEED_RESET);
            end
         endcase
         if (p == 1) begin
            fork
               begin
                  hold_off = 1;
                  repeat (400) @(posedge clock);
                  hold_off = 0;
               end
               repeat (6) other(OP_TICK, 31'($urandom_range(0, 1 << 16)));
            join
         end
         repeat (21) run_motion();
         repeat (6) run_motion();
         drain();
      end
      if (board.errors == 0 && board.pending.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl
rtl/rtap_pkg.sv
rtl/rtap_div.sv
rtl/rtap_mul.sv
rtl/rotate_then_advance_trapezoid_profiler.sv
verif/tb_rotate_then_advance_trapezoid_profiler.sv
